/* rtl/core/shutter_updown_timeout_control_defines.svh */
// ----------------------------------------------------------------------------
// Shutter up/down timeout control: assertion macros
// Shared property macros for the checker of the shutter control block.
// ----------------------------------------------------------------------------
`ifndef SHUTTER_UPDOWN_TIMEOUT_CONTROL_DEFINES_SVH
`define SHUTTER_UPDOWN_TIMEOUT_CONTROL_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SUTC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("shutter control: same-cycle property failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SUTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("shutter control: next-cycle property failed");

`endif

/* rtl/core/sutc_pkg.sv */
// ----------------------------------------------------------------------------
// Shutter up/down timeout control: package
// Word types, action codes, register indexes and reset constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sutc_pkg;

  // Number of shutter channels supported by the register map.
  localparam int unsigned MaxChannels = 5;
  localparam int unsigned ChanW       = 3;
  localparam int unsigned TimeW       = 32;
  localparam int unsigned CfgIdxW     = 3;

  // Timeout values after reset, in milliseconds.
  localparam logic [TimeW-1:0] TIMEOUT_RST_CH0   = 32'd10000;
  localparam logic [TimeW-1:0] TIMEOUT_RST_OTHER = 32'd20000;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_CH0       = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BUTTON_ACTIVE_LOW = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_RELAY_ACTIVE_LOW  = 3'd6;

  // Per-channel action.
  typedef enum logic [1:0] {
    ACT_IDLE = 2'd0,
    ACT_UP   = 2'd1,
    ACT_DOWN = 2'd2
  } action_e;

  // One poll of one channel.
  typedef struct packed {
    logic [ChanW-1:0] shutter;
    logic             down_level;
    logic             up_level;
    logic [TimeW-1:0] now_ms;
  } poll_t;

  // Relay drive result of one poll.
  typedef struct packed {
    logic [ChanW-1:0] shutter_out;
    logic             relay_one_level;
    logic             relay_two_level;
    logic [1:0]       motion;
    logic             relay_changed;
  } result_t;

  // Reset timeout of a channel.
  function automatic logic [TimeW-1:0] timeout_reset(input int unsigned ch);
    return (ch == 0) ? TIMEOUT_RST_CH0 : TIMEOUT_RST_OTHER;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/shutter_updown_timeout_control.sv */
// Flow: a poll word accepted into the input register passes to the result register
// when that is free. Throughput: one poll word per cycle while the result side does
// not stall; the per-channel state is read and written back as the word moves
// from the input register to the result register, so the next poll of the same channel sees it.
// Reset: every channel idle with both buttons released, timeouts 10000 ms for
// channel zero and 20000 ms for the rest, buttons and relays active low.
// ----------------------------------------------------------------------------
// Shutter up/down timeout control
// Edge-triggered up/down shutter control with a per-channel run-time limit.
// ----------------------------------------------------------------------------
`default_nettype none

module shutter_updown_timeout_control #(
  parameter int unsigned CHANNELS = sutc_pkg::MaxChannels
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // Poll channel
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire sutc_pkg::poll_t            in_data_i,
  // Result channel
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output sutc_pkg::result_t               out_data_o,
  // Configuration write channel
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire [sutc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire [sutc_pkg::TimeW-1:0]       cfg_data_i
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers.
  logic [sutc_pkg::TimeW-1:0] timeout_q [CHANNELS];
  logic                       btn_al_q;
  logic                       relay_al_q;

  // Per-channel state.
  sutc_pkg::action_e          action_q   [CHANNELS];
  logic [sutc_pkg::TimeW-1:0] start_q    [CHANNELS];
  logic                       down_was_q [CHANNELS];
  logic                       up_was_q   [CHANNELS];

  // Input register and result register.
  sutc_pkg::poll_t   in_q;
  logic              in_valid_q;
  sutc_pkg::result_t out_q, out_d;
  logic              out_valid_q;

  logic              advance;
  logic              in_accept;
  logic              in_range;
  logic [IdxW-1:0]   ch;

  // Combinational per-poll values.
  logic                       down_pressed, up_pressed;
  logic                       down_edge, up_edge;
  sutc_pkg::action_e          act0, act1, act2, act3;
  logic [sutc_pkg::TimeW-1:0] st0, st1, st2;
  logic [sutc_pkg::TimeW-1:0] elapsed;
  logic                       timed_out;
  logic                       changed;

  // Handshake: the input register drains whenever the result register is free.
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign in_range = (in_q.shutter < sutc_pkg::ChanW'(CHANNELS));
  assign ch       = in_q.shutter[IdxW-1:0];

  // Button edges, action update and timeout check for the polled channel.
  always_comb begin
    down_pressed = in_q.down_level ^ btn_al_q;
    up_pressed   = in_q.up_level ^ btn_al_q;
    down_edge    = down_pressed && !down_was_q[ch];
    up_edge      = up_pressed && !up_was_q[ch];
    act0         = action_q[ch];
    st0          = start_q[ch];

    act1 = act0;
    st1  = st0;
    if (down_edge) begin
      if (act0 == sutc_pkg::ACT_IDLE) begin
        act1 = sutc_pkg::ACT_DOWN;
        st1  = in_q.now_ms;
      end else begin
        act1 = sutc_pkg::ACT_IDLE;
      end
    end

    act2 = act1;
    st2  = st1;
    if (up_edge) begin
      if (act1 == sutc_pkg::ACT_IDLE) begin
        act2 = sutc_pkg::ACT_UP;
        st2  = in_q.now_ms;
      end else begin
        act2 = sutc_pkg::ACT_IDLE;
      end
    end

    // Elapsed time wraps modulo two to the 32.
    elapsed   = in_q.now_ms - st2;
    timed_out = (act2 != sutc_pkg::ACT_IDLE) && (elapsed >= timeout_q[ch]);
    act3      = timed_out ? sutc_pkg::ACT_IDLE : act2;
    changed   = down_edge || up_edge || timed_out;
  end

  // Result word.
  always_comb begin
    out_d.shutter_out     = in_q.shutter;
    out_d.motion          = 2'(sutc_pkg::ACT_IDLE);
    out_d.relay_changed   = 1'b0;
    if (in_range) begin
      out_d.motion        = 2'(act3);
      out_d.relay_changed = changed;
    end
    out_d.relay_one_level = (out_d.motion == 2'(sutc_pkg::ACT_UP)) ? !relay_al_q : relay_al_q;
    out_d.relay_two_level = (out_d.motion == 2'(sutc_pkg::ACT_DOWN)) ? !relay_al_q : relay_al_q;
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  // Per-channel state, written back as the word moves to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        action_q[i]   <= sutc_pkg::ACT_IDLE;
        start_q[i]    <= '0;
        down_was_q[i] <= 1'b0;
        up_was_q[i]   <= 1'b0;
      end
    end else if (advance && in_range) begin
      action_q[ch]   <= act3;
      start_q[ch]    <= st2;
      down_was_q[ch] <= down_pressed;
      up_was_q[ch]   <= up_pressed;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        timeout_q[i] <= sutc_pkg::timeout_reset(i);
      end
      btn_al_q   <= 1'b1;
      relay_al_q <= 1'b1;
    end else if (cfg_valid_i) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (cfg_index_i == sutc_pkg::CFG_TIMEOUT_CH0 + sutc_pkg::CfgIdxW'(i)) begin
          timeout_q[i] <= cfg_data_i;
        end
      end
      if (cfg_index_i == sutc_pkg::CFG_BUTTON_ACTIVE_LOW) begin
        btn_al_q <= cfg_data_i[0];
      end
      if (cfg_index_i == sutc_pkg::CFG_RELAY_ACTIVE_LOW) begin
        relay_al_q <= cfg_data_i[0];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sutc_checker.sv */
// ----------------------------------------------------------------------------
// Shutter up/down timeout control: port checker
// Properties over the top-level ports, attached to the block by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shutter_updown_timeout_control_defines.svh"

module sutc_checker #(
  parameter int unsigned CHANNELS = sutc_pkg::MaxChannels
) (
  input wire                         clk_i,
  input wire                         rst_ni,
  input wire                         in_ready_o,
  input wire                         out_valid_o,
  input wire                         out_ready_i,
  input wire sutc_pkg::result_t      out_data_o,
  input wire                         cfg_valid_i,
  input wire                         cfg_ready_o
);

  logic stalled;
  logic idle_motion;
  logic out_of_range;
  logic relays_same;

  assign stalled      = out_valid_o && !out_ready_i;
  assign idle_motion  = (out_data_o.motion == 2'(sutc_pkg::ACT_IDLE));
  assign out_of_range = (out_data_o.shutter_out >= sutc_pkg::ChanW'(CHANNELS));
  assign relays_same  = (out_data_o.relay_one_level == out_data_o.relay_two_level);

  // A stalled result word stays valid and unchanged.
  `SUTC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, stalled, out_valid_o && $stable(out_data_o))

  // Configuration writes are never back-pressured.
  `SUTC_ASSERT_IMPL(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_o)

  // Relays differ exactly when the shutter moves, so both never drive together.
  `SUTC_ASSERT_IMPL(a_relay_motion, clk_i, rst_ni, out_valid_o, (relays_same == idle_motion))

  // A poll of a channel that does not exist leaves the relays idle.
  `SUTC_ASSERT_IMPL(a_bad_channel, clk_i, rst_ni, out_valid_o && out_of_range, idle_motion && !out_data_o.relay_changed)

  // With the result side empty the block always takes a new poll.
  `SUTC_ASSERT_IMPL(a_ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o)

endmodule

bind shutter_updown_timeout_control sutc_checker #(
  .CHANNELS(CHANNELS)
) u_sutc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o),
  .cfg_valid_i(cfg_valid_i),
  .cfg_ready_o(cfg_ready_o)
);

`default_nettype wire
